// ===== src/page_region_allocator_top_defines.svh =====
// ----------------------------------------------------------------------------
// Page region allocator assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef PAGE_REGION_ALLOCATOR_TOP_DEFINES_SVH
`define PAGE_REGION_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define PRA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define PRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== src/pra_pkg.sv =====
// ----------------------------------------------------------------------------
// Page region allocator package
// Payload types, codes, reset values and page rounding shared by the allocator, checker and testbench.
// ----------------------------------------------------------------------------
package pra_pkg;

	localparam int REGION_SLOTS_DEF = 16;
	localparam int PAGE_BYTES_DEF   = 4096;

	localparam logic [31:0] AREA_TOP_RST = 32'h0040_0000;
	localparam logic [31:0] AREA_LOW_RST = 32'h0000_0000;

	// Request codes
	localparam logic REQ_MAP   = 1'b0;
	localparam logic REQ_UNMAP = 1'b1;

	// Configuration register indexes
	localparam logic CFG_AREA_TOP = 1'b0;
	localparam logic CFG_AREA_LOW = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [31:0] region_address;
		logic [31:0] byte_length;
	} req_t;

	typedef struct packed {
		logic        failed;
		logic [31:0] mapped_base;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_UNMAP,
		ST_FINISH
	} pra_state_t;

	// Control from the top level into the allocator core
	typedef struct packed {
		logic start;
		logic res_room;
	} pra_ctl_t;

	// Status from the allocator core
	typedef struct packed {
		logic idle;
		logic done;
		rsp_t rsp;
	} pra_status_t;

	// Round up to a whole page; mask is the page alignment mask
	function automatic logic [31:0] pra_round_up(input logic [31:0] v, input logic [31:0] mask);
		return (v + ~mask) & mask;
	endfunction

endpackage

// ===== src/pra_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pra_ram #(
	parameter int WIDTH  = 64,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== src/pra_ctrl.sv =====
// ----------------------------------------------------------------------------
// Page region allocator core
// Sequencer that walks the slot table in RAM for map scans and unmap lookups.
// ----------------------------------------------------------------------------
`include "page_region_allocator_top_defines.svh"

module pra_ctrl import pra_pkg::*; #(
	parameter int REGION_SLOTS = REGION_SLOTS_DEF,
	parameter int PAGE_BYTES   = PAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  pra_ctl_t    ctl,
	input  req_t        req,
	input  logic [31:0] area_top,
	input  logic [31:0] area_low,
	output pra_status_t status
);

	localparam int IDX_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
	localparam int CNT_W = $clog2(REGION_SLOTS + 1);
	localparam logic [31:0] PAGE_W    = 32'(PAGE_BYTES);
	localparam logic [31:0] PAGE_MASK = ~(PAGE_W - 32'd1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REGION_SLOTS - 1);
	localparam logic [CNT_W-1:0] SLOT_CNT = CNT_W'(REGION_SLOTS);

	pra_state_t state_q, state_d;

	logic              type_q;
	logic [31:0]       addr_q;
	logic [31:0]       len_q;
	logic              blen_zero_q;
	logic [31:0]       cand_q;
	logic [IDX_W-1:0]  free_q;
	logic [CNT_W-1:0]  rd_k_q;
	logic              chk_valid_s1;
	logic [IDX_W-1:0]  chk_k_s1;
	logic [REGION_SLOTS-1:0] used_q;
	rsp_t              res_q, res_d;

	logic              free_found;
	logic [IDX_W-1:0]  free_idx;
	logic [31:0]       diff, cand0, cand_next;
	logic              map_bad, step_end;
	logic [63:0]       rd_data;
	logic [31:0]       slot_b, slot_l;
	logic              chk_used, collide, last_chk, unmap_hit;
	logic              issue, load, restart, set_res, done;
	logic              map_commit, unmap_commit;

	// Lowest-numbered free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int k = REGION_SLOTS - 1; k >= 0; k--) begin
			if (!used_q[k]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(k);
			end
		end
	end

	assign diff      = area_top - area_low;
	assign cand0     = (area_top - len_q) & PAGE_MASK;
	assign map_bad   = blen_zero_q || (len_q == 32'd0) || (len_q > diff) || !free_found ||
		(cand0 < area_low);
	assign cand_next = cand_q - PAGE_W;
	assign step_end  = (cand_q < PAGE_W) || (cand_next < area_low);

	assign slot_b    = rd_data[63:32];
	assign slot_l    = rd_data[31:0];
	assign chk_used  = used_q[chk_k_s1];
	assign collide   = chk_valid_s1 && chk_used && (cand_q < slot_b + slot_l) &&
		(cand_q + len_q > slot_b);
	assign last_chk  = chk_valid_s1 && (chk_k_s1 == LAST_IDX);
	assign unmap_hit = chk_valid_s1 && chk_used && (slot_b == addr_q) &&
		((len_q == 32'd0) || (len_q == slot_l));

	always_comb begin
		state_d      = state_q;
		res_d        = '0;
		issue        = 1'b0;
		load         = 1'b0;
		restart      = 1'b0;
		set_res      = 1'b0;
		done         = 1'b0;
		map_commit   = 1'b0;
		unmap_commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (ctl.start) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				load = 1'b1;
				if (type_q == REQ_MAP) begin
					if (map_bad) begin
						set_res      = 1'b1;
						res_d.failed = 1'b1;
					end else begin
						state_d = ST_SCAN;
					end
				end else begin
					if (addr_q == 32'd0) begin
						set_res      = 1'b1;
						res_d.failed = 1'b1;
					end else begin
						state_d = ST_UNMAP;
					end
				end
			end
			ST_SCAN: begin
				if (collide) begin
					// Drop this candidate; step one page down, or fail if that leaves the area
					if (step_end) begin
						set_res      = 1'b1;
						res_d.failed = 1'b1;
					end else begin
						restart = 1'b1;
					end
				end else if (last_chk) begin
					map_commit        = 1'b1;
					set_res           = 1'b1;
					res_d.mapped_base = cand_q;
				end else begin
					issue = (rd_k_q < SLOT_CNT);
				end
			end
			ST_UNMAP: begin
				if (unmap_hit) begin
					unmap_commit = 1'b1;
					set_res      = 1'b1;
				end else if (last_chk) begin
					set_res      = 1'b1;
					res_d.failed = 1'b1;
				end else begin
					issue = (rd_k_q < SLOT_CNT);
				end
			end
			ST_FINISH: begin
				if (ctl.res_room) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (set_res) begin
			state_d = ST_FINISH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			chk_valid_s1 <= 1'b0;
			used_q       <= '0;
			rd_k_q       <= '0;
		end else begin
			state_q      <= state_d;
			chk_valid_s1 <= issue;
			if (load || restart) begin
				rd_k_q <= '0;
			end else if (issue) begin
				rd_k_q <= rd_k_q + CNT_W'(1);
			end
			if (map_commit) begin
				used_q[free_q] <= 1'b1;
			end
			if (unmap_commit) begin
				used_q[chk_k_s1] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			type_q      <= req.req_type;
			addr_q      <= req.region_address;
			len_q       <= pra_round_up(req.byte_length, PAGE_MASK);
			blen_zero_q <= (req.byte_length == 32'd0);
		end
		if (load) begin
			cand_q <= cand0;
			free_q <= free_idx;
		end else if (restart) begin
			cand_q <= cand_next;
		end
		chk_k_s1 <= rd_k_q[IDX_W-1:0];
		if (set_res) begin
			res_q <= res_d;
		end
	end

	pra_ram #(
		.WIDTH (64),
		.DEPTH (REGION_SLOTS)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (map_commit),
		.wr_addr (free_q),
		.wr_data ({cand_q, len_q}),
		.rd_en   (issue),
		.rd_addr (rd_k_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	assign status.idle = (state_q == ST_IDLE);
	assign status.done = done;
	assign status.rsp  = res_q;

	`PRA_ASSERT_IMPL(a_start_idle, clk, arst_n, ctl.start, state_q == ST_IDLE)
	`PRA_ASSERT_IMPL(a_done_room, clk, arst_n, done, ctl.res_room)
	`PRA_ASSERT_IMPL(a_fail_no_base, clk, arst_n, done && res_q.failed,
		res_q.mapped_base == 32'd0)
	`PRA_ASSERT_NEXT(a_commit_used, clk, arst_n, map_commit, used_q[$past(free_q)])
	`PRA_ASSERT_IMPL(a_chk_busy, clk, arst_n, chk_valid_s1,
		state_q == ST_SCAN || state_q == ST_UNMAP)

endmodule

// ===== src/page_region_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Page region allocator
// Top-down first-fit allocator of page-aligned regions over a slot table.
// ----------------------------------------------------------------------------
//  channel | signals                          | item
//  --------+----------------------------------+------------------------------
//  req     | req_valid, req_ready, req        | map or unmap request
//  rsp     | rsp_valid, rsp_ready, rsp        | failed flag and mapped base
//  cfg     | cfg_valid, cfg_ready, cfg_index, | area_top / area_low write
//          | cfg_data                         |
//
// Slot bases and lengths sit in one RAM read one slot per cycle. A map is
// decoded, then tests candidate pages from the top down, reading slots up to
// and including the first colliding one, or all slots for the candidate that
// fits. An unmap reads slots until a match or the last slot. Used marks are
// flip-flops cleared at reset, so there is no clearing pass. A result waits in
// the rsp register; one more request is taken and its result holds until rsp
// drains.
// ----------------------------------------------------------------------------
module page_region_allocator_top import pra_pkg::*; #(
	parameter int REGION_SLOTS = REGION_SLOTS_DEF,
	parameter int PAGE_BYTES   = PAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] area_top_q, area_low_q;
	logic        rsp_valid_q;
	rsp_t        rsp_q;
	pra_ctl_t    ctl;
	pra_status_t status;

	assign cfg_ready    = 1'b1;
	assign req_ready    = status.idle;
	assign ctl.start    = req_valid && status.idle;
	assign ctl.res_room = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_top_q  <= AREA_TOP_RST;
			area_low_q  <= AREA_LOW_RST;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_AREA_TOP: area_top_q <= cfg_data;
					CFG_AREA_LOW: area_low_q <= cfg_data;
					default: ;
				endcase
			end
			if (status.done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (status.done) begin
			rsp_q <= status.rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	pra_ctrl #(
		.REGION_SLOTS (REGION_SLOTS),
		.PAGE_BYTES   (PAGE_BYTES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.req      (req),
		.area_top (area_top_q),
		.area_low (area_low_q),
		.status   (status)
	);

endmodule

// ===== dv/page_region_allocator_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Page region allocator checker
// Watches the cfg, req and rsp channels, keeps its own copy of the area bounds
// and the region table, works out the result of every accepted request and
// compares each accepted result against the oldest one still awaited.
// ----------------------------------------------------------------------------
module page_region_allocator_checker import pra_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  req_t        req,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  rsp_t        rsp,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          pending
);

	localparam int          SLOTS = REGION_SLOTS_DEF;
	localparam logic [31:0] PAGE  = PAGE_BYTES_DEF;

	logic [31:0] area_hi;
	logic [31:0] area_lo;
	logic        in_use   [SLOTS];
	logic [31:0] base_tab [SLOTS];
	logic [31:0] span_tab [SLOTS];

	rsp_t        awaited [$];
	rsp_t        want;
	logic [31:0] got;
	bit          ok;
	int          fail_tally;

	function automatic logic [31:0] page_ceil(input logic [31:0] v);
		return (v + PAGE - 32'd1) & ~(PAGE - 32'd1);
	endfunction

	// Ends wrap at 32 bits, so a region running past the top never collides.
	function automatic bit span_hits(input logic [31:0] start, input logic [31:0] span);
		logic [31:0] used_end;
		logic [31:0] new_end;
		for (int k = 0; k < SLOTS; k++) begin
			used_end = base_tab[k] + span_tab[k];
			new_end  = start + span;
			if (in_use[k] && start < used_end && new_end > base_tab[k])
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit place_region(input logic [31:0] want_len, output logic [31:0] at);
		logic [31:0] span;
		logic [31:0] room;
		logic [31:0] probe;
		int          spare;
		at    = '0;
		spare = -1;
		if (want_len == 32'd0)
			return 1'b0;
		span = page_ceil(want_len);
		room = area_hi - area_lo;
		if (span == 32'd0 || span > room)
			return 1'b0;
		for (int k = SLOTS - 1; k >= 0; k--)
			if (!in_use[k])
				spare = k;
		if (spare < 0)
			return 1'b0;
		probe = (area_hi - span) & ~(PAGE - 32'd1);
		while (probe >= area_lo) begin
			if (!span_hits(probe, span)) begin
				base_tab[spare] = probe;
				span_tab[spare] = span;
				in_use[spare]   = 1'b1;
				at              = probe;
				return 1'b1;
			end
			// page zero is the last candidate
			if (probe < PAGE)
				return 1'b0;
			probe = probe - PAGE;
		end
		return 1'b0;
	endfunction

	// A length that rounds to zero matches on the base alone.
	function automatic bit free_region(input logic [31:0] addr, input logic [31:0] len);
		logic [31:0] span;
		span = page_ceil(len);
		if (addr == 32'd0)
			return 1'b0;
		for (int k = 0; k < SLOTS; k++) begin
			if (in_use[k] && base_tab[k] == addr && (span == 32'd0 || span == span_tab[k])) begin
				in_use[k] = 1'b0;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic report(input string msg);
		fail_tally++;
		if (fail_tally <= 10)
			$display("%0t: mismatch: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_hi = AREA_TOP_RST;
			area_lo = AREA_LOW_RST;
			for (int k = 0; k < SLOTS; k++)
				in_use[k] = 1'b0;
			awaited.delete();
			fail_tally = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_AREA_TOP: area_hi = cfg_data;
					CFG_AREA_LOW: area_lo = cfg_data;
					default: ;
				endcase
			end
			// retire results before adding this edge's request
			if (rsp_valid && rsp_ready) begin
				if (awaited.size() == 0) begin
					report($sformatf("result failed=%0b base=%h with nothing awaited",
						rsp.failed, rsp.mapped_base));
				end else begin
					want = awaited.pop_front();
					if (rsp.failed !== want.failed)
						report($sformatf("failed: expected %0b, actual %0b",
							want.failed, rsp.failed));
					if (rsp.mapped_base !== want.mapped_base)
						report($sformatf("mapped_base: expected %h, actual %h",
							want.mapped_base, rsp.mapped_base));
				end
			end
			if (req_valid && req_ready) begin
				got = '0;
				if (req.req_type == REQ_MAP)
					ok = place_region(req.byte_length, got);
				else
					ok = free_region(req.region_address, req.byte_length);
				want.failed      = !ok;
				want.mapped_base = ok ? got : 32'd0;
				awaited.push_back(want);
			end
			errors  <= fail_tally;
			pending <= awaited.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Page region allocator testbench
// Directed map and unmap corner cases at the reset area bounds, then random
// map/unmap traffic over several area settings and idle patterns, including
// a long result hold-off. Checking is done by the checker instance.
// ----------------------------------------------------------------------------
module testbench;
	import pra_pkg::*;

	localparam logic [31:0] PAGE = PAGE_BYTES_DEF;

	typedef struct packed {
		logic [31:0] base;
		logic [31:0] raw_len;
	} region_rec_t;

	typedef struct packed {
		logic [31:0] top_a;
		logic [31:0] low_a;
		logic [1:0]  idle_mode;
		logic [6:0]  map_pct;
		logic [3:0]  max_pg;
	} phase_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req       = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_t        rsp;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_AREA_TOP;
	logic [31:0] cfg_data  = '0;
	int          errors;
	int          pending;

	int          send_idle_pct = 0;
	int          stall_pct     = 0;
	int          hold_requests = 0;
	int          hold_seen     = 0;
	int          hold_left     = 0;
	req_t        sent_log [$];
	req_t        done_req;
	region_rec_t live_regions [$];
	phase_t      plan [8];

	page_region_allocator_top dut (.*);

	page_region_allocator_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_left != 0) begin
			rsp_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_requests) begin
			hold_seen <= hold_requests;
			hold_left <= 400;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// remember mapped regions so unmaps can hit them
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready && sent_log.size() != 0) begin
			done_req = sent_log.pop_front();
			if (done_req.req_type == REQ_MAP && !rsp.failed) begin
				live_regions.push_back('{rsp.mapped_base, done_req.byte_length});
				if (live_regions.size() > 48)
					void'(live_regions.pop_front());
			end
		end
	end

	function automatic req_t map_item(input logic [31:0] len);
		req_t r;
		r.req_type       = REQ_MAP;
		r.region_address = $urandom();
		r.byte_length    = len;
		return r;
	endfunction

	function automatic req_t unmap_item(input logic [31:0] addr, input logic [31:0] len);
		req_t r;
		r.req_type       = REQ_UNMAP;
		r.region_address = addr;
		r.byte_length    = len;
		return r;
	endfunction

	task automatic offer(input req_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sent_log.push_back(item);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_area(input logic [31:0] top_a, input logic [31:0] low_a);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_AREA_TOP;
		cfg_data  <= top_a;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_index <= CFG_AREA_LOW;
		cfg_data  <= low_a;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		#100_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	initial begin
		region_rec_t rec;
		logic [31:0] len;
		logic [31:0] addr;
		int          roll;
		int          pick;
		int          pages;
		int          pg;

		plan[0] = '{32'h0004_0000, 32'h0000_0000, 2'd0, 7'd65, 4'd4};
		plan[1] = '{32'h0002_0000, 32'h0001_0000, 2'd1, 7'd60, 4'd2};
		plan[2] = '{32'hFFFF_FFFF, 32'hFFFC_0000, 2'd2, 7'd60, 4'd4};
		plan[3] = '{32'h0000_3000, 32'hFFFF_E000, 2'd3, 7'd55, 4'd3};
		plan[4] = '{32'h0000_0000, 32'hFFFF_FFFF, 2'd0, 7'd50, 4'd2};
		plan[5] = '{32'h0000_8000, 32'h0000_0000, 2'd1, 7'd65, 4'd2};
		plan[6] = '{32'h8000_0000, 32'h7FFC_0000, 2'd2, 7'd55, 4'd8};
		plan[7] = '{32'h0040_0000, 32'h003C_0000, 2'd3, 7'd70, 4'd1};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset bounds: top 4 MiB, low 0
		offer(map_item(32'h0000_0000));
		offer(map_item(32'hFFFF_FFFF));
		offer(map_item(32'hFFFF_F001));
		offer(map_item(32'h0040_0001));
		offer(map_item(32'h003F_F000));
		offer(map_item(32'h0000_2000));
		offer(unmap_item(32'h0000_0000, 32'h0000_0000));
		offer(unmap_item(32'h0000_1000, 32'h003F_F001));
		offer(unmap_item(32'h0000_5000, 32'h0000_0000));
		offer(unmap_item(32'h0000_1000, 32'hFFFF_FFFF));
		offer(map_item(32'h0000_0001));
		offer(map_item(32'h0000_1001));
		offer(unmap_item(32'h003F_F000, 32'h0000_1000));
		offer(unmap_item(32'h003F_D000, 32'h0000_2000));
		offer(map_item(32'hFFFF_F000));
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_area(plan[ph].top_a, plan[ph].low_a);
			@(posedge clk);
			case (plan[ph].idle_mode)
				2'd0: begin send_idle_pct = 0;  stall_pct = 0;  end
				2'd1: begin send_idle_pct = 87; stall_pct = 0;  end
				2'd2: begin send_idle_pct = 0;  stall_pct = 87; end
				default: begin send_idle_pct = 32; stall_pct = 32; end
			endcase
			pg    = int'(plan[ph].max_pg);
			pages = (plan[ph].top_a - plan[ph].low_a) / PAGE;
			if (pages > 64)
				pages = 64;
			for (int n = 0; n < 155; n++) begin
				// fill the block while results are held back
				if (ph == 0 && n == 20)
					hold_requests <= hold_requests + 1;
				roll = $urandom_range(99);
				if (roll < plan[ph].map_pct) begin
					roll = $urandom_range(99);
					if (roll < 60)
						len = $urandom_range(pg * PAGE, 1);
					else if (roll < 75)
						len = $urandom_range(pg, 1) * PAGE;
					else if (roll < 85)
						len = $urandom();
					else if (roll < 90)
						len = 32'd0;
					else if (roll < 95)
						len = 32'hFFFF_F000 | $urandom_range(4095, 0);
					else
						len = (plan[ph].top_a - plan[ph].low_a) + $urandom_range(1, 0);
					offer(map_item(len));
				end else begin
					roll = $urandom_range(99);
					if (live_regions.size() != 0 && roll < 75) begin
						pick = $urandom_range(live_regions.size() - 1, 0);
						rec  = live_regions[pick];
						addr = rec.base;
						roll = $urandom_range(99);
						if (roll < 40) begin
							len = 32'd0;
							live_regions.delete(pick);
						end else if (roll < 75) begin
							len = rec.raw_len;
							live_regions.delete(pick);
						end else if (roll < 90) begin
							len = rec.raw_len + PAGE;
						end else begin
							len = $urandom();
						end
					end else if (roll < 92) begin
						addr = plan[ph].low_a + $urandom_range(pages, 0) * PAGE;
						len  = ($urandom_range(1) != 0) ? 32'd0 : $urandom();
					end else begin
						addr = ($urandom_range(1) != 0) ? 32'd0 : $urandom();
						len  = $urandom();
					end
					offer(unmap_item(addr, len));
				end
			end
			drain();
		end

		if (errors == 0 && pending == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
